// ===== hw/rtl/ir_pulse_distance_tx_32bit_unit_defines.svh =====
// Assertion macros for the infrared transmitter. The checks are compiled out when SYNTH is set.
`ifndef IR_PULSE_DISTANCE_TX_32BIT_UNIT_DEFINES_SVH
`define IR_PULSE_DISTANCE_TX_32BIT_UNIT_DEFINES_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define IRPDTX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// When the antecedent holds, the consequent must hold in the next cycle.
`define IRPDTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IRPDTX_ASSERT(lbl, clk, rst_n, prop, msg)
`define IRPDTX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/irpdtx_pkg.sv =====
`timescale 1ns / 1ps

package irpdtx_pkg;

  // Frame sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HBURST  = 3'd1,
    PH_HSPACE  = 3'd2,
    PH_BBURST  = 3'd3,
    PH_BSPACE  = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  // Kind of request once the front end has decoded it.
  typedef enum logic {
    ITEM_TICK  = 1'b0,
    ITEM_START = 1'b1
  } item_kind_t;

  // One queued request: its kind and, for a start, the assembled 32-bit frame.
  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] frame;
  } item_t;

  // Front end to queue.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_push_t;

  // Queue head offered to the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CARRIER_HIGH  = 3'd0;
  localparam logic [2:0] CFG_CARRIER_LOW   = 3'd1;
  localparam logic [2:0] CFG_HEADER_BURST  = 3'd2;
  localparam logic [2:0] CFG_HEADER_SPACE  = 3'd3;
  localparam logic [2:0] CFG_BIT_BURST     = 3'd4;
  localparam logic [2:0] CFG_ONE_SPACE     = 3'd5;
  localparam logic [2:0] CFG_ZERO_SPACE    = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_CARRIER_HIGH = 8'd8;
  localparam logic [7:0]  RST_CARRIER_LOW  = 8'd17;
  localparam logic [9:0]  RST_HEADER_BURST = 10'd344;
  localparam logic [13:0] RST_HEADER_SPACE = 14'd4700;
  localparam logic [7:0]  RST_BIT_BURST    = 8'd21;
  localparam logic [13:0] RST_ONE_SPACE    = 14'd1665;
  localparam logic [13:0] RST_ZERO_SPACE   = 14'd665;

  // Bit position of the last frame bit plus one; reaching it starts the trailer.
  localparam logic [5:0] FRAME_BITS = 6'd32;

endpackage

// ===== hw/rtl/irpdtx_ifs.sv =====
`timescale 1ns / 1ps

// Request channel: one tick or start request per transfer.
interface irpdtx_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] command_byte;

  modport source (output valid, action, first_byte, second_byte, command_byte, input ready);
  modport sink   (input valid, action, first_byte, second_byte, command_byte, output ready);
endinterface

// Result channel: one result per request.
interface irpdtx_out_if;
  logic valid;
  logic ready;
  logic ir_level;
  logic busy_res;
  logic rejected;
  logic frame_done;

  modport source (output valid, ir_level, busy_res, rejected, frame_done, input ready);
  modport sink   (input valid, ir_level, busy_res, rejected, frame_done, output ready);
endinterface

// Configuration write channel.
interface irpdtx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [13:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/irpdtx_front.sv =====
`timescale 1ns / 1ps

module irpdtx_front
  import irpdtx_pkg::*;
(
  irpdtx_in_if.sink in_ch,
  input  logic      q_full,
  output q_push_t   push
);

  // Accept whenever the queue has room; decode the request and assemble the frame word.
  assign in_ch.ready = !q_full;

  always_comb begin
    push.valid      = in_ch.valid && in_ch.ready;
    push.item.kind  = in_ch.action ? ITEM_START : ITEM_TICK;
    push.item.frame = {in_ch.first_byte, in_ch.second_byte,
                       in_ch.command_byte, ~in_ch.command_byte};
  end

endmodule

// ===== hw/rtl/irpdtx_fifo.sv =====
`timescale 1ns / 1ps

module irpdtx_fifo
  import irpdtx_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  output logic    full,
  output q_head_t head,
  input  logic    pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign head.valid = (count_r != '0);
  assign head.item  = store[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= push.item;
    end
  end

endmodule

// ===== hw/rtl/irpdtx_back.sv =====
`timescale 1ns / 1ps
`include "ir_pulse_distance_tx_32bit_unit_defines.svh"

module irpdtx_back
  import irpdtx_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  q_head_t       head,
  output logic          pop,
  irpdtx_cfg_if.sink    cfg_ch,
  irpdtx_out_if.source  out_ch
);

  // Configuration registers.
  logic [7:0]  cfg_high_r, cfg_low_r, cfg_bit_per_r;
  logic [9:0]  cfg_hdr_per_r;
  logic [13:0] cfg_hdr_space_r, cfg_one_space_r, cfg_zero_space_r;

  // Sequencer state.
  phase_t      phase_r, phase_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic [5:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  ctick_r, ctick_nxt;
  logic [9:0]  bpc_r, bpc_nxt;
  logic [13:0] space_r, space_nxt;
  logic        low_half_r, low_half_nxt;

  // Output register.
  logic        out_valid_r;
  logic        level_r, busy_r, rej_r, done_r;
  logic        level_c, busy_c, rej_c, done_c;

  // Shared burst and space arithmetic.
  logic [7:0]  half_lim;
  logic [8:0]  ctick_inc;
  logic        half_end;
  logic [9:0]  periods, per_lim;
  logic [10:0] bpc_inc;
  logic        per_end, burst_end;
  logic        cur_bit;
  logic [13:0] bit_space_lim;
  logic [14:0] space_inc;
  logic [5:0]  bit_inc;
  phase_t      after_bit;
  logic        is_start, is_burst;

  assign pop      = head.valid && (!out_valid_r || out_ch.ready);
  assign is_start = (head.item.kind == ITEM_START);
  assign is_burst = (phase_r == PH_HBURST) || (phase_r == PH_BBURST) || (phase_r == PH_TRAILER);

  always_comb begin
    if (low_half_r) begin
      half_lim = (cfg_low_r == '0) ? 8'd1 : cfg_low_r;
    end else begin
      half_lim = (cfg_high_r == '0) ? 8'd1 : cfg_high_r;
    end
    ctick_inc     = {1'b0, ctick_r} + 9'd1;
    half_end      = (ctick_inc >= {1'b0, half_lim});
    periods       = (phase_r == PH_HBURST) ? cfg_hdr_per_r : {2'b00, cfg_bit_per_r};
    per_lim       = (periods == '0) ? 10'd1 : periods;
    bpc_inc       = {1'b0, bpc_r} + 11'd1;
    per_end       = (bpc_inc >= {1'b0, per_lim});
    burst_end     = half_end && low_half_r && per_end;
    cur_bit       = frame_r[5'd31 - bit_idx_r[4:0]];
    bit_space_lim = cur_bit ? cfg_one_space_r : cfg_zero_space_r;
    space_inc     = {1'b0, space_r} + 15'd1;
    bit_inc       = bit_idx_r + 6'd1;
    after_bit     = (bit_inc >= FRAME_BITS) ? PH_TRAILER : PH_BBURST;
  end

  // Next state of the sequencer.
  always_comb begin
    phase_nxt    = phase_r;
    frame_nxt    = frame_r;
    bit_idx_nxt  = bit_idx_r;
    ctick_nxt    = ctick_r;
    bpc_nxt      = bpc_r;
    space_nxt    = space_r;
    low_half_nxt = low_half_r;
    if (pop) begin
      if (is_start) begin
        if (phase_r == PH_IDLE) begin
          frame_nxt    = head.item.frame;
          bit_idx_nxt  = '0;
          space_nxt    = '0;
          ctick_nxt    = '0;
          bpc_nxt      = '0;
          low_half_nxt = 1'b0;
          phase_nxt    = PH_HBURST;
        end
      end else begin
        // Carrier timing is common to every burst; a burst end leaves the counters cleared.
        if (is_burst) begin
          if (!half_end) begin
            ctick_nxt = ctick_inc[7:0];
          end else begin
            ctick_nxt = '0;
            if (!low_half_r) begin
              low_half_nxt = 1'b1;
            end else begin
              low_half_nxt = 1'b0;
              bpc_nxt      = per_end ? '0 : bpc_inc[9:0];
            end
          end
        end
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_HBURST: begin
            if (burst_end) begin
              bit_idx_nxt = '0;
              space_nxt   = '0;
              phase_nxt   = (cfg_hdr_space_r == '0) ? PH_BBURST : PH_HSPACE;
            end
          end
          PH_HSPACE: begin
            if (space_inc >= {1'b0, cfg_hdr_space_r}) begin
              space_nxt    = '0;
              ctick_nxt    = '0;
              bpc_nxt      = '0;
              low_half_nxt = 1'b0;
              phase_nxt    = PH_BBURST;
            end else begin
              space_nxt = space_inc[13:0];
            end
          end
          PH_BBURST: begin
            if (burst_end) begin
              space_nxt = '0;
              if (bit_space_lim == '0) begin
                bit_idx_nxt = bit_inc;
                phase_nxt   = after_bit;
              end else begin
                phase_nxt = PH_BSPACE;
              end
            end
          end
          PH_BSPACE: begin
            if (space_inc >= {1'b0, bit_space_lim}) begin
              space_nxt    = '0;
              ctick_nxt    = '0;
              bpc_nxt      = '0;
              low_half_nxt = 1'b0;
              bit_idx_nxt  = bit_inc;
              phase_nxt    = after_bit;
            end else begin
              space_nxt = space_inc[13:0];
            end
          end
          PH_TRAILER: begin
            if (burst_end) begin
              bit_idx_nxt = '0;
              phase_nxt   = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result fields of the request now leaving the queue.
  always_comb begin
    level_c = 1'b1;
    busy_c  = 1'b0;
    rej_c   = 1'b0;
    done_c  = 1'b0;
    if (is_start) begin
      busy_c = 1'b1;
      rej_c  = (phase_r != PH_IDLE);
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_HBURST, PH_BBURST: begin
          busy_c  = 1'b1;
          level_c = !low_half_r;
        end
        PH_TRAILER: begin
          busy_c  = 1'b1;
          level_c = !low_half_r;
          done_c  = burst_end;
        end
        PH_HSPACE, PH_BSPACE: begin
          busy_c = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_idx_r  <= '0;
      ctick_r    <= '0;
      bpc_r      <= '0;
      space_r    <= '0;
      low_half_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bit_idx_r  <= bit_idx_nxt;
      ctick_r    <= ctick_nxt;
      bpc_r      <= bpc_nxt;
      space_r    <= space_nxt;
      low_half_r <= low_half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      level_r <= level_c;
      busy_r  <= busy_c;
      rej_r   <= rej_c;
      done_r  <= done_c;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ir_level   = level_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.rejected   = rej_r;
  assign out_ch.frame_done = done_r;

  // Configuration writes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_high_r       <= RST_CARRIER_HIGH;
      cfg_low_r        <= RST_CARRIER_LOW;
      cfg_hdr_per_r    <= RST_HEADER_BURST;
      cfg_hdr_space_r  <= RST_HEADER_SPACE;
      cfg_bit_per_r    <= RST_BIT_BURST;
      cfg_one_space_r  <= RST_ONE_SPACE;
      cfg_zero_space_r <= RST_ZERO_SPACE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_CARRIER_HIGH: cfg_high_r       <= cfg_ch.data[7:0];
        CFG_CARRIER_LOW:  cfg_low_r        <= cfg_ch.data[7:0];
        CFG_HEADER_BURST: cfg_hdr_per_r    <= cfg_ch.data[9:0];
        CFG_HEADER_SPACE: cfg_hdr_space_r  <= cfg_ch.data;
        CFG_BIT_BURST:    cfg_bit_per_r    <= cfg_ch.data[7:0];
        CFG_ONE_SPACE:    cfg_one_space_r  <= cfg_ch.data;
        CFG_ZERO_SPACE:   cfg_zero_space_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  `IRPDTX_ASSERT_NEXT(a_done_to_idle, clk, rst_n, pop && done_c, phase_r == PH_IDLE, "frame end did not return to idle")
  `IRPDTX_ASSERT(a_idle_clean, clk, rst_n, (phase_r != PH_IDLE) || (!low_half_r && ctick_r == '0 && bpc_r == '0), "carrier counters not cleared in idle")
  `IRPDTX_ASSERT(a_trailer_index, clk, rst_n, (phase_r != PH_TRAILER) || (bit_idx_r == FRAME_BITS), "trailer entered before all bits were sent")

endmodule

// ===== hw/rtl/ir_pulse_distance_tx_32bit_unit.sv =====
`timescale 1ns / 1ps
// Pulse-distance infrared transmitter for 32-bit frames, driven by microsecond tick requests.
// in_ch carries one request per transfer: a tick (action 0) advances the waveform by one
// microsecond, a start (action 1) loads both address bytes and the command byte and begins a
// frame, or is rejected when a frame is already under way. Every request yields exactly one
// result on out_ch: the pin level for that tick, busy, rejected and frame-done flags.
// cfg_ch writes the seven timing registers by index; it is always ready and should only be
// used while no frame is being sent and all results have been collected.
// An accepted request is written into the queue; the sequencer takes it from the queue head and
// its result is held in the output register. One request is taken every cycle for as long as
// results are collected, since the sequencer updates all of its counters at once for each tick.
// When the receiver stalls, the result is held in the output register and new requests fill
// the queue between front end and sequencer; in_ch.ready falls only once the queue is full.
// Reset (rst_n low at a clock edge) empties the queue and the output register, returns the
// sequencer to idle and restores the timing registers to their default values.
module ir_pulse_distance_tx_32bit_unit
  import irpdtx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  irpdtx_in_if.sink    in_ch,
  irpdtx_out_if.source out_ch,
  irpdtx_cfg_if.sink   cfg_ch
);

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Front end: decodes requests and builds the frame word.
  irpdtx_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push)
  );

  // Short queue so that the request side and the result side stall independently.
  irpdtx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  // Back end: frame sequencer, timing registers and output register.
  irpdtx_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule
